// File: design/rapc_pkg.sv
// Shared types and constants for the region access permission checker.
// Holds request/response structs, the probe handed along the cell chain,
// operation codes and controller states. Depends on nothing.
package rapc_pkg;

  localparam int MAX_REGIONS_DEFAULT = 8;
  localparam int ADDR_WIDTH_DEFAULT  = 32;

  localparam logic [7:0] THRESHOLD_RESET = 8'd3;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_CHECK = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] address;
    logic [31:0] size;
    logic [2:0]  access;
    logic [31:0] region_start;
    logic [31:0] region_end;
    logic [2:0]  region_perms;
  } req_t;

  typedef struct packed {
    logic        allowed;
    logic        violation;
    logic [2:0]  violating_region;
    logic        degraded_request;
    logic        table_full_error;
    logic [31:0] violations_seen;
    logic [3:0]  regions_in_use;
  } rsp_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] size;
    logic [2:0]  access;
    logic        hit;
  } probe_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// File: design/rapc_cell.sv
// One region cell: holds a start, an exclusive end and a permission mask,
// and passes the access probe on to the next cell with its denial verdict.
// Depends on rapc_pkg.
module rapc_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 3,
  parameter int AW    = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_start,
  input  logic [AW-1:0]     wr_end,
  input  logic [2:0]        wr_perms,
  input  logic              in_use,
  input  rapc_pkg::probe_t  probe_in,
  input  logic [IW-1:0]     idx_in,
  output rapc_pkg::probe_t  probe_out,
  output logic [IW-1:0]     idx_out
);

  logic [AW-1:0] region_start;
  logic [AW-1:0] region_end;
  logic [2:0]    region_perms;

  logic [AW-1:0] addr;
  logic [AW-1:0] gap;
  logic          overlap;
  logic          deny;

  rapc_pkg::probe_t probe_next;
  logic [IW-1:0]    idx_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      region_start <= wr_start;
      region_end   <= wr_end;
      region_perms <= wr_perms;
    end
  end

  assign addr = probe_in.address[AW-1:0];
  assign gap  = region_start - addr;

  always_comb begin
    overlap = 1'b0;
    if (addr < region_end) begin
      if (addr > region_start) begin
        overlap = 1'b1;
      end else begin
        overlap = probe_in.size > 32'(gap);
      end
    end
  end

  assign deny = in_use && (probe_in.access != 3'd0) && overlap &&
                ((region_perms & probe_in.access) != probe_in.access);

  always_comb begin
    probe_next     = probe_in;
    probe_next.hit = probe_in.hit || deny;
  end

  assign idx_next = (!probe_in.hit && deny) ? IW'(INDEX) : idx_in;

  always_ff @(posedge clk) begin
    probe_out <= probe_next;
    idx_out   <= idx_next;
  end

endmodule

// File: design/region_access_permission_checker.sv
// Top level of the region access permission checker: controller, counters,
// response register and the chain of region cells.
// Depends on rapc_pkg and rapc_cell.
//
//  channel | signals                    | payload
//  --------+----------------------------+---------------------
//  request | req_valid, req_ready       | req  (rapc_pkg::req_t)
//  response| rsp_valid, rsp_ready       | rsp  (rapc_pkg::rsp_t)
//  config  | cfg_we                     | cfg_wdata (threshold)
//
// During a check the probe walks the cell chain one cell per cycle while the
// controller scans; add, clear and unused codes skip the scan and finish.
// One request is in flight at a time; a new request is taken once the last
// has moved into the response register, even while that response waits.
// A stalled response holds the controller in its finishing state.
// Reset empties the table and clears the violation count; threshold is 3.
module region_access_permission_checker #(
  parameter int MAX_REGIONS = rapc_pkg::MAX_REGIONS_DEFAULT,
  parameter int ADDR_WIDTH  = rapc_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  rapc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rapc_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata
);

  localparam int AW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [IW-1:0] LAST_CELL = IW'(MAX_REGIONS - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_REGIONS);

  rapc_pkg::state_t state, state_next;
  rapc_pkg::req_t   held;
  logic [IW-1:0]    scan_count;
  logic [CW-1:0]    used;
  logic [31:0]      denials;
  logic [7:0]       threshold;

  logic             finish;
  logic             table_full;
  logic             do_add;
  logic [CW-1:0]    used_next;
  logic [31:0]      denials_next;
  logic [31:0]      used_wide;
  logic [31:0]      idx_wide;
  rapc_pkg::rsp_t   result;

  rapc_pkg::probe_t          probe [MAX_REGIONS+1];
  logic [IW-1:0]             idx   [MAX_REGIONS+1];
  logic [MAX_REGIONS-1:0]    in_use;
  logic [MAX_REGIONS-1:0]    wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rapc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    finish     = 1'b0;
    unique case (state)
      rapc_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = (req.op == rapc_pkg::OP_CHECK) ? rapc_pkg::ST_SCAN
                                                       : rapc_pkg::ST_FINISH;
        end
      end
      rapc_pkg::ST_SCAN: begin
        if (scan_count == LAST_CELL) begin
          state_next = rapc_pkg::ST_FINISH;
        end
      end
      rapc_pkg::ST_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          finish     = 1'b1;
          state_next = rapc_pkg::ST_IDLE;
        end
      end
      default: state_next = rapc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      held <= req;
    end
    if (state == rapc_pkg::ST_SCAN) begin
      scan_count <= scan_count + IW'(1);
    end else begin
      scan_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= rapc_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Cell chain
  assign probe[0] = '{address: held.address, size: held.size,
                      access: held.access, hit: 1'b0};
  assign idx[0]   = '0;

  for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
    assign in_use[g] = used > CW'(g);
    assign wr_en[g]  = do_add && (used == CW'(g));

    rapc_cell #(
      .INDEX (g),
      .IW    (IW),
      .AW    (AW)
    ) u_cell (
      .clk       (clk),
      .wr_en     (wr_en[g]),
      .wr_start  (held.region_start[AW-1:0]),
      .wr_end    (held.region_end[AW-1:0]),
      .wr_perms  (held.region_perms),
      .in_use    (in_use[g]),
      .probe_in  (probe[g]),
      .idx_in    (idx[g]),
      .probe_out (probe[g+1]),
      .idx_out   (idx[g+1])
    );
  end

  // Result and state update
  assign table_full = (used == FULL_COUNT);
  assign do_add     = finish && (held.op == rapc_pkg::OP_ADD) && !table_full;

  always_comb begin
    used_next    = used;
    denials_next = denials;
    result       = '0;
    unique case (held.op)
      rapc_pkg::OP_CHECK: begin
        result.allowed   = !probe[MAX_REGIONS].hit;
        result.violation = probe[MAX_REGIONS].hit;
        if (probe[MAX_REGIONS].hit) begin
          if (denials != rapc_pkg::COUNT_MAX) begin
            denials_next = denials + 32'd1;
          end
          result.violating_region = idx_wide[2:0];
          result.degraded_request = denials_next >= 32'(threshold);
        end
      end
      rapc_pkg::OP_ADD: begin
        result.table_full_error = table_full;
        if (!table_full) begin
          used_next = used + CW'(1);
        end
      end
      rapc_pkg::OP_CLEAR: begin
        used_next    = '0;
        denials_next = '0;
      end
      default: ;
    endcase
    used_wide              = 32'(used_next);
    result.violations_seen = denials_next;
    result.regions_in_use  = used_wide[3:0];
  end

  assign idx_wide = 32'(idx[MAX_REGIONS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      denials <= '0;
    end else if (finish) begin
      used    <= used_next;
      denials <= denials_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (finish) begin
      rsp <= result;
    end
  end

endmodule
